FILE: rtl/core/sample_packer_rle_encoder_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sample packer and run length encoder.
// Both macros expect clock in the calling scope, SPRE_ASSERT also reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_PACKER_RLE_ENCODER_MACROS_SVH
`define SAMPLE_PACKER_RLE_ENCODER_MACROS_SVH

// Checked on every rising edge except while reset is high.
`define SPRE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SPRE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/spre_pkg.sv
// ----------------------------------------------------------------------------
// spre_pkg
// Shared types and constants of the sample packer and run length encoder:
// field widths, opcodes, register indexes and reset values, the byte source
// select and the command and status bundles of controller and datapath.
// ----------------------------------------------------------------------------
package spre_pkg;

   // Field widths of the channels and the register port.
   localparam int OPCODE_W     = 2;
   localparam int SAMPLE_W     = 8;
   localparam int OUT_DATA_W   = 32;
   localparam int OUT_COUNT_W  = 3;
   localparam int CSR_ADDR_W   = 1;
   localparam int CSR_DATA_W   = 4;

   // Input opcodes.
   localparam logic [OPCODE_W-1:0] OP_SAMPLE    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ROW_END   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_IMAGE_END = 2'd2;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_RLE_ENABLE      = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BITS_PER_SAMPLE = 1'd1;

   // Register reset values.
   localparam logic       RLE_ENABLE_RESET      = 1'b0;
   localparam logic [3:0] BITS_PER_SAMPLE_RESET = 4'd8;

   // Source of the byte sent to the beat packer.
   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_PENDING,
      EMIT_HEADER,
      EMIT_LAST,
      EMIT_RDATA
   } emit_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         take_item;
      logic         open_partial;
      logic         merge;
      emit_sel_type emit_sel;
      logic         store;
      logic         set_last;
      logic         clr_repeat;
      logic         run_one;
      logic         run_step;
      logic         count_trim;
      logic         count_fix;
      logic         send_finish;
      logic         rd_first;
      logic         rd_next;
      logic         close;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                split_needed;
      logic                merge_full;
      logic                filled_nz;
      logic                rle_on;
      logic                repeat_on;
      logic                count_nz;
      logic                count_full;
      logic                count_gt2;
      logic                x_eq_last;
      logic                run_hit;
      logic                byte_ok;
      logic                lit_last;
      logic                close_done;
   } status_type;

endpackage

FILE: rtl/core/spre_req_if.sv
// ----------------------------------------------------------------------------
// spre_req_if
// Input channel: one opcode and one sample per transfer.
// ----------------------------------------------------------------------------
interface spre_req_if;

   logic                          valid;
   logic                          ready;
   logic [spre_pkg::OPCODE_W-1:0] opcode;
   logic [spre_pkg::SAMPLE_W-1:0] sample_value;

   modport source (output valid, output opcode, output sample_value, input ready);
   modport sink   (input valid, input opcode, input sample_value, output ready);

endinterface

FILE: rtl/core/spre_rsp_if.sv
// ----------------------------------------------------------------------------
// spre_rsp_if
// Result channel: up to four packed bytes per transfer.
// ----------------------------------------------------------------------------
interface spre_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [spre_pkg::OUT_DATA_W-1:0]  out_data;
   logic [spre_pkg::OUT_COUNT_W-1:0] out_count;
   logic                             out_last;

   modport source (output valid, output out_data, output out_count, output out_last,
                   input ready);
   modport sink   (input valid, input out_data, input out_count, input out_last,
                   output ready);

endinterface

FILE: rtl/core/spre_ctrl.sv
// ----------------------------------------------------------------------------
// spre_ctrl
// Sequencer of the encoder. It walks one input item through packing, the
// run length decisions and packet sends, one step per cycle while the output
// is not stalled, and drives the datapath through a command bundle.
// ----------------------------------------------------------------------------
module spre_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  spre_pkg::status_type status,
   output spre_pkg::cmd_type    cmd
);
   import spre_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECIDE   = 4'd1;
   localparam logic [3:0] S_MERGE    = 4'd2;
   localparam logic [3:0] S_FLUSH    = 4'd3;
   localparam logic [3:0] S_PUT      = 4'd4;
   localparam logic [3:0] S_PUSH     = 4'd5;
   localparam logic [3:0] S_SEND_HDR = 4'd6;
   localparam logic [3:0] S_SEND_REP = 4'd7;
   localparam logic [3:0] S_SEND_LIT = 4'd8;
   localparam logic [3:0] S_RUNFIX   = 4'd9;
   localparam logic [3:0] S_CLOSE    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [3:0] put_ret_ff, put_ret_in;
   logic [3:0] send_ret_ff, send_ret_in;

   assign req_ready = (state_ff == S_IDLE);

   // Next state, return points and commands.
   always_comb begin
      state_in    = state_ff;
      put_ret_in  = put_ret_ff;
      send_ret_in = send_ret_ff;
      cmd         = '0;
      cmd.emit_sel = EMIT_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end

         // A sample that does not fit closes the partial byte first; a flush
         // closes any partial byte before the buffer goes out.
         S_DECIDE: begin
            unique case (status.op)
               OP_SAMPLE: begin
                  if (status.split_needed) begin
                     cmd.open_partial = 1'b1;
                     put_ret_in       = S_MERGE;
                     state_in         = S_PUT;
                  end else begin
                     state_in = S_MERGE;
                  end
               end
               OP_ROW_END, OP_IMAGE_END: begin
                  if (status.filled_nz) begin
                     cmd.open_partial = 1'b1;
                     put_ret_in       = S_FLUSH;
                     state_in         = S_PUT;
                  end else begin
                     state_in = S_FLUSH;
                  end
               end
               default: begin
                  state_in = S_CLOSE;
               end
            endcase
         end

         S_MERGE: begin
            cmd.merge = 1'b1;
            if (status.merge_full) begin
               put_ret_in = S_CLOSE;
               state_in   = S_PUT;
            end else begin
               state_in = S_CLOSE;
            end
         end

         S_FLUSH: begin
            if (status.count_nz) begin
               send_ret_in = S_CLOSE;
               state_in    = S_SEND_HDR;
            end else begin
               state_in = S_CLOSE;
            end
         end

         // A finished byte goes straight out in plain mode, or to the encoder in run
         // length mode, once any full buffer has been sent.
         S_PUT: begin
            if (!status.rle_on) begin
               cmd.emit_sel = EMIT_PENDING;
               if (status.byte_ok) begin
                  state_in = put_ret_ff;
               end
            end else if (status.count_full) begin
               send_ret_in = S_PUSH;
               state_in    = S_SEND_HDR;
            end else begin
               state_in = S_PUSH;
            end
         end

         // Run length decision for one byte.
         S_PUSH: begin
            priority if (status.repeat_on && !status.count_nz) begin
               cmd.store    = 1'b1;
               cmd.set_last = 1'b1;
               state_in     = put_ret_ff;
            end else if (status.repeat_on && status.x_eq_last) begin
               cmd.store = 1'b1;
               state_in  = put_ret_ff;
            end else if (status.repeat_on && status.count_gt2) begin
               send_ret_in = S_PUSH;
               state_in    = S_SEND_HDR;
            end else if (status.repeat_on) begin
               cmd.clr_repeat = 1'b1;
               cmd.store      = 1'b1;
               cmd.set_last   = 1'b1;
               cmd.run_one    = 1'b1;
               state_in       = put_ret_ff;
            end else if (status.x_eq_last) begin
               cmd.run_step = 1'b1;
               if (status.run_hit) begin
                  cmd.count_trim = 1'b1;
                  send_ret_in    = S_RUNFIX;
                  state_in       = S_SEND_HDR;
               end else begin
                  cmd.store = 1'b1;
                  state_in  = put_ret_ff;
               end
            end else begin
               cmd.store    = 1'b1;
               cmd.set_last = 1'b1;
               cmd.run_one  = 1'b1;
               state_in     = put_ret_ff;
            end
         end

         S_SEND_HDR: begin
            cmd.emit_sel = EMIT_HEADER;
            if (status.byte_ok) begin
               if (status.repeat_on) begin
                  state_in = S_SEND_REP;
               end else begin
                  cmd.rd_first = 1'b1;
                  state_in     = S_SEND_LIT;
               end
            end
         end

         S_SEND_REP: begin
            cmd.emit_sel = EMIT_LAST;
            if (status.byte_ok) begin
               cmd.send_finish = 1'b1;
               state_in        = send_ret_ff;
            end
         end

         // One buffered byte per transfer into the packer; the next read is
         // issued in the same cycle.
         S_SEND_LIT: begin
            cmd.emit_sel = EMIT_RDATA;
            if (status.byte_ok) begin
               if (status.lit_last) begin
                  cmd.send_finish = 1'b1;
                  state_in        = send_ret_ff;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end

         // The four equal bytes carry on as a repeat run.
         S_RUNFIX: begin
            cmd.count_fix = 1'b1;
            state_in      = put_ret_ff;
         end

         S_CLOSE: begin
            cmd.close = 1'b1;
            if (status.close_done) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         put_ret_ff  <= S_CLOSE;
         send_ret_ff <= S_CLOSE;
      end else begin
         state_ff    <= state_in;
         put_ret_ff  <= put_ret_in;
         send_ret_ff <= send_ret_in;
      end
   end

endmodule

FILE: rtl/core/spre_datapath.sv
// ----------------------------------------------------------------------------
// spre_datapath
// Registers, run buffer and byte path of the encoder: sample packing, run
// length state, packet headers, the beat packer and the result register.
// ----------------------------------------------------------------------------
module spre_datapath #(
   parameter int BUFFER_DEPTH   = 128,
   parameter int BYTES_PER_BEAT = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [spre_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [spre_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic                                csr_wr_en,
   input  logic [spre_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [spre_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  spre_pkg::cmd_type                   cmd,
   output spre_pkg::status_type                status,
   spre_rsp_if.source                          rsp_chan
);
   import spre_pkg::*;

   localparam int BEAT_BYTES = (BYTES_PER_BEAT > 4) ? 4 :
                               ((BYTES_PER_BEAT < 1) ? 1 : BYTES_PER_BEAT);
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CNT_W-1:0]       CNT_FULL  = CNT_W'(BUFFER_DEPTH);
   localparam logic [OUT_COUNT_W-1:0] BEAT_FULL = OUT_COUNT_W'(BEAT_BYTES);

   // Registers and their next values.
   logic                         rle_ff, rle_in;
   logic [3:0]                   bps_ff, bps_in;
   logic [OPCODE_W-1:0]          op_ff;
   logic [SAMPLE_W-1:0]          sample_ff;
   logic [7:0]                   partial_ff, partial_in;
   logic [3:0]                   filled_ff, filled_in;
   logic [7:0]                   pending_ff, pending_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         repeat_ff, repeat_in;
   logic [7:0]                   last_ff, last_in;
   logic [2:0]                   run_ff, run_in;
   logic [ADDR_W-1:0]            idx_ff, idx_in;
   logic [7:0]                   rd_data_ff;
   logic [OUT_DATA_W-1:0]        beat_data_ff, beat_data_in;
   logic [OUT_COUNT_W-1:0]       beat_cnt_ff, beat_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0]        rsp_data_ff;
   logic [OUT_COUNT_W-1:0]       rsp_count_ff;
   logic                         rsp_last_ff;

   logic [7:0] run_buffer_mem [BUFFER_DEPTH];

   // Combinational helpers.
   logic [3:0]        w_eff;
   logic [8:0]        mask9;
   logic [7:0]        sample_bits;
   logic [4:0]        fill_sum;
   logic [3:0]        shift_amt;
   logic [7:0]        merged_val;
   logic [7:0]        header_byte;
   logic [7:0]        emit_byte;
   logic              emit_fire;
   logic              out_free;
   logic              byte_ok;
   logic              load_out;
   logic              load_last;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [2:0]        run_next;

   // Effective sample width: 3 rounds up to 4, 0 and anything above 4 to 8.
   always_comb begin
      unique case (bps_ff)
         4'd1:       w_eff = 4'd1;
         4'd2:       w_eff = 4'd2;
         4'd3, 4'd4: w_eff = 4'd4;
         default:    w_eff = 4'd8;
      endcase
   end

   // Sample packing, MSB first.
   assign mask9       = (9'd1 << w_eff) - 9'd1;
   assign sample_bits = sample_ff & mask9[7:0];
   assign fill_sum    = 5'(filled_ff) + 5'(w_eff);
   assign shift_amt   = 4'd8 - filled_ff - w_eff;
   assign merged_val  = partial_ff | (sample_bits << shift_amt);

   // Packet header: repeat packets count down from 256, literal ones are n-1.
   assign header_byte = repeat_ff ? 8'(9'd256 - 9'(count_ff))
                                  : 8'(count_ff - CNT_W'(1));

   assign run_next = run_ff + 3'd1;

   // Byte into the beat packer.
   always_comb begin
      unique case (cmd.emit_sel)
         EMIT_PENDING: emit_byte = pending_ff;
         EMIT_HEADER:  emit_byte = header_byte;
         EMIT_LAST:    emit_byte = last_ff;
         EMIT_RDATA:   emit_byte = rd_data_ff;
         default:      emit_byte = 8'd0;
      endcase
   end

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign byte_ok   = (beat_cnt_ff != BEAT_FULL) || out_free;
   assign emit_fire = (cmd.emit_sel != EMIT_NONE) && byte_ok;

   // Status toward the controller.
   always_comb begin
      status.op           = op_ff;
      status.split_needed = fill_sum > 5'd8;
      status.merge_full   = fill_sum >= 5'd8;
      status.filled_nz    = filled_ff != 4'd0;
      status.rle_on       = rle_ff;
      status.repeat_on    = repeat_ff;
      status.count_nz     = count_ff != '0;
      status.count_full   = count_ff >= CNT_FULL;
      status.count_gt2    = count_ff > CNT_W'(2);
      status.x_eq_last    = pending_ff == last_ff;
      status.run_hit      = run_next > 3'd3;
      status.byte_ok      = byte_ok;
      status.lit_last     = (CNT_W'(idx_ff) + CNT_W'(1)) >= count_ff;
      status.close_done   = (beat_cnt_ff == '0) || out_free;
   end

   // Configuration registers.
   always_comb begin
      rle_in = rle_ff;
      bps_in = bps_ff;
      if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_RLE_ENABLE:      rle_in = csr_wr_data[0];
            CSR_BITS_PER_SAMPLE: bps_in = csr_wr_data;
            default:             rle_in = rle_ff;
         endcase
      end
   end

   // Partial byte and the byte waiting to be placed.
   always_comb begin
      partial_in = partial_ff;
      filled_in  = filled_ff;
      pending_in = pending_ff;
      if (cmd.open_partial) begin
         pending_in = partial_ff;
         partial_in = 8'd0;
         filled_in  = 4'd0;
      end else if (cmd.merge) begin
         if (fill_sum >= 5'd8) begin
            pending_in = merged_val;
            partial_in = 8'd0;
            filled_in  = 4'd0;
         end else begin
            partial_in = merged_val;
            filled_in  = fill_sum[3:0];
         end
      end
   end

   // Run length state.
   always_comb begin
      count_in  = count_ff;
      repeat_in = repeat_ff;
      last_in   = last_ff;
      run_in    = run_ff;

      priority if (cmd.send_finish) begin
         count_in = '0;
      end else if (cmd.count_trim) begin
         count_in = count_ff - CNT_W'(run_ff);
      end else if (cmd.count_fix) begin
         count_in = CNT_W'(run_ff);
      end else if (cmd.store) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (cmd.send_finish) begin
         repeat_in = 1'b1;
      end else if (cmd.clr_repeat) begin
         repeat_in = 1'b0;
      end

      if (cmd.set_last) begin
         last_in = pending_ff;
      end

      if (cmd.run_one) begin
         run_in = 3'd1;
      end else if (cmd.run_step) begin
         run_in = run_next;
      end
   end

   // Run buffer read pointer.
   assign rd_en   = cmd.rd_first || cmd.rd_next;
   assign rd_addr = cmd.rd_first ? '0 : idx_ff + ADDR_W'(1);
   assign idx_in  = rd_en ? rd_addr : idx_ff;

   // Beat packer: a full beat is handed on only when the next byte arrives or
   // the item closes, so the final beat of an item can carry the last flag.
   always_comb begin
      beat_data_in = beat_data_ff;
      beat_cnt_in  = beat_cnt_ff;
      load_out     = 1'b0;
      load_last    = 1'b0;
      if (emit_fire) begin
         if (beat_cnt_ff == BEAT_FULL) begin
            load_out     = 1'b1;
            beat_data_in = {emit_byte, 24'd0};
            beat_cnt_in  = OUT_COUNT_W'(1);
         end else if (beat_cnt_ff == '0) begin
            beat_data_in = {emit_byte, 24'd0};
            beat_cnt_in  = OUT_COUNT_W'(1);
         end else begin
            for (int i = 1; i < 4; i++) begin
               if (beat_cnt_ff == OUT_COUNT_W'(i)) begin
                  beat_data_in[OUT_DATA_W-1-8*i -: 8] = emit_byte;
               end
            end
            beat_cnt_in = beat_cnt_ff + OUT_COUNT_W'(1);
         end
      end else if (cmd.close && (beat_cnt_ff != '0) && out_free) begin
         load_out    = 1'b1;
         load_last   = 1'b1;
         beat_cnt_in = '0;
      end
   end

   // Result register.
   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_data  = rsp_data_ff;
   assign rsp_chan.out_count = rsp_count_ff;
   assign rsp_chan.out_last  = rsp_last_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rle_ff       <= RLE_ENABLE_RESET;
         bps_ff       <= BITS_PER_SAMPLE_RESET;
         partial_ff   <= 8'd0;
         filled_ff    <= 4'd0;
         count_ff     <= '0;
         repeat_ff    <= 1'b1;
         last_ff      <= 8'd0;
         run_ff       <= 3'd0;
         beat_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rle_ff       <= rle_in;
         bps_ff       <= bps_in;
         partial_ff   <= partial_in;
         filled_ff    <= filled_in;
         count_ff     <= count_in;
         repeat_ff    <= repeat_in;
         last_ff      <= last_in;
         run_ff       <= run_in;
         beat_cnt_ff  <= beat_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         op_ff     <= req_opcode;
         sample_ff <= req_sample;
      end
      pending_ff   <= pending_in;
      idx_ff       <= idx_in;
      beat_data_ff <= beat_data_in;
      if (load_out) begin
         rsp_data_ff  <= beat_data_ff;
         rsp_count_ff <= beat_cnt_ff;
         rsp_last_ff  <= load_last;
      end
   end

   // Run buffer: one write port at the fill count, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         run_buffer_mem[count_ff[ADDR_W-1:0]] <= pending_ff;
      end
      if (rd_en) begin
         rd_data_ff <= run_buffer_mem[rd_addr];
      end
   end

endmodule

FILE: rtl/core/sample_packer_rle_encoder.sv
// ----------------------------------------------------------------------------
// sample_packer_rle_encoder
// One item at a time: a sample completing no byte passes decide, merge and close;
// a completed byte adds put, and push in run length mode; a packet send adds a send
// step per byte, header included. A flush passes decide, flush and close plus its
// bytes, plus put steps if it closes a partial byte. The last result is registered
// as the item closes. Reset is synchronous and clears control state only.
// ----------------------------------------------------------------------------
module sample_packer_rle_encoder #(
   parameter int BUFFER_DEPTH   = 128,
   parameter int BYTES_PER_BEAT = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   spre_req_if.sink                        req_chan,
   spre_rsp_if.source                      rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [spre_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [spre_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import spre_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   spre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath with run buffer and result register.
   spre_datapath #(
      .BUFFER_DEPTH   (BUFFER_DEPTH),
      .BYTES_PER_BEAT (BYTES_PER_BEAT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_opcode  (req_chan.opcode),
      .req_sample  (req_chan.sample_value),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_chan    (rsp_chan)
   );

endmodule

FILE: rtl/core/spre_checker.sv
// ----------------------------------------------------------------------------
// spre_checker
// Port level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_packer_rle_encoder_macros.svh"

module spre_checker (
   input logic        clock,
   input logic        reset,
   spre_req_if.sink   req_chan,
   spre_rsp_if.source rsp_chan
);

   // A stalled result keeps its place and its payload.
   `SPRE_ASSERT(a_rsp_hold, rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.out_data) && $stable(rsp_chan.out_count) && $stable(rsp_chan.out_last), "result changed while stalled")

   // A beat carries one to four bytes.
   `SPRE_ASSERT(a_rsp_count, rsp_chan.valid |-> rsp_chan.out_count != 3'd0 && rsp_chan.out_count <= 3'd4, "byte count out of range")

   // Unused low bytes of a short beat are zero.
   `SPRE_ASSERT(a_rsp_pad, rsp_chan.valid |-> (rsp_chan.out_count != 3'd1 || rsp_chan.out_data[23:0] == 24'd0) && (rsp_chan.out_count != 3'd2 || rsp_chan.out_data[15:0] == 16'd0) && (rsp_chan.out_count != 3'd3 || rsp_chan.out_data[7:0] == 8'd0), "short beat not zero padded")

   // Items are worked one at a time, so a transfer drops ready.
   `SPRE_ASSERT(a_req_one_item, req_chan.valid && req_chan.ready |=> !req_chan.ready, "second item taken while busy")

   // Reset leaves the block idle with no result pending.
   `SPRE_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_chan.valid && req_chan.ready, "not idle after reset")

endmodule

bind sample_packer_rle_encoder spre_checker u_spre_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
